// File: rtl/mma_pkg.sv
// Shared constants, register codes and helper functions for the modular
// multiply-add core. No dependencies.
`default_nettype none

package mma_pkg;

  localparam int ModBits     = 62;
  localparam int OperandBits = 63;
  localparam int WordBits    = 64;
  localparam int Stages      = 14;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_MODULUS        = 2'd0,
    REG_BARRETT_FACTOR = 2'd1,
    REG_INPUT_FACTOR   = 2'd2
  } cfg_reg_t;

  // Barrett pre-shift: bit length of q minus two (zero for q below 2)
  function automatic logic [5:0] barrett_shift(input logic [ModBits-1:0] q);
    logic [6:0] len;
    len = 7'd0;
    for (int i = 0; i < ModBits; i++) begin
      if (q[i]) len = 7'(i + 1);
    end
    return (len >= 7'd2) ? 6'(len - 7'd2) : 6'd0;
  endfunction

  // log2 of the effective operand bound: 0 and 1 act as 1, else round down
  function automatic logic [1:0] factor_log(input logic [3:0] f);
    logic [1:0] k;
    if (f >= 4'd8) k = 2'd3;
    else if (f >= 4'd4) k = 2'd2;
    else if (f >= 4'd2) k = 2'd1;
    else k = 2'd0;
    return k;
  endfunction

  // One conditional-subtraction step
  function automatic logic [WordBits-1:0] cond_sub(input logic [WordBits-1:0] x,
                                                   input logic [WordBits-1:0] m);
    return (x >= m) ? (x - m) : x;
  endfunction

endpackage

`default_nettype wire

// File: rtl/modular_multiply_add_core.sv
// Top level of the modular multiply-add core: (a*b + c) mod q per item with
// Barrett reduction. Depends on mma_pkg.
`default_nettype none

// The core takes one item per clock while in_stall is low and returns one result
// item per input item, in order. The 14-stage pipeline has a range check and
// three conditional-subtraction stages for the operands, a 62x62 product built
// from four 31x31 partial products and summed in the next stage, the Barrett
// pre-shift, the 64x64 quotient estimate (four 32x32 partial products, then a
// sum), the low product of the estimate and q, the remainder plus addend, and
// three final subtraction stages. Each stage holds its own valid bit and
// advances when the stage after it is empty or moving, so bubbles close up and
// out_stall only holds back as many stages as are full. in_stall rises only
// when every stage holds an item and the output is stalled. An operand at or
// above 2^k*q, with 2^k the input factor rounded down to a power of two (0 acts
// as 1), sets range_error and forces residue to zero; q of 0 or 1 also gives
// zero. Write configuration only while no item is in flight; the Barrett shift
// is derived from the modulus at write time, and barrett_factor must be
// floor(2^(L+62)/q) for L the bit length of q, or residue is not reduced.
module modular_multiply_add_core (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // configuration write port
  input  wire logic                               cfg_write,
  input  wire logic [1:0]                         cfg_index,
  input  wire logic [mma_pkg::WordBits-1:0]       cfg_data,
  // input channel
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [mma_pkg::OperandBits-1:0]    operand_a,
  input  wire logic [mma_pkg::OperandBits-1:0]    operand_b,
  input  wire logic [mma_pkg::OperandBits-1:0]    addend,
  input  wire logic                               last_in,
  // output channel
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [mma_pkg::ModBits-1:0]             residue,
  output logic                                    range_error,
  output logic                                    last_out
);

  localparam int N = mma_pkg::Stages;
  localparam int W = mma_pkg::WordBits;
  localparam int M = mma_pkg::ModBits;

  // Configuration registers
  logic [M-1:0] modulus;
  logic [W-1:0] barrett_factor;
  logic [1:0]   bound_log;
  logic [5:0]   shift_amt;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus        <= M'(2);
      barrett_factor <= '0;
      bound_log      <= 2'd0;
      shift_amt      <= 6'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        mma_pkg::REG_MODULUS: begin
          modulus   <= cfg_data[M-1:0];
          shift_amt <= mma_pkg::barrett_shift(cfg_data[M-1:0]);
        end
        mma_pkg::REG_BARRETT_FACTOR: begin
          barrett_factor <= cfg_data;
        end
        mma_pkg::REG_INPUT_FACTOR: begin
          bound_log <= mma_pkg::factor_log(cfg_data[3:0]);
        end
        default: begin
        end
      endcase
    end
  end

  // Multiples of q used by the subtraction stages
  logic [W-1:0] q1, q2, q4;
  assign q1 = {2'b00, modulus};
  assign q2 = {1'b0, modulus, 1'b0};
  assign q4 = {modulus, 2'b00};

  // Stage flow control: a stage loads when it is empty or its successor loads
  logic [N-1:0] v;
  logic [N-1:0] en;

  always_comb begin
    en[N-1] = !v[N-1] || !out_stall;
    for (int i = N - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v[N-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int i = 1; i < N; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  // Side flags that travel with each item
  logic [N-2:0] last_p;   // copy of last_in
  logic [N-2:1] err_p;    // operand out of range
  logic [N-2:1] zero_p;   // force residue to zero

  // Stage payloads
  logic [mma_pkg::OperandBits-1:0] a_s0, b_s0, c_s0;
  logic [W-1:0]   a_s1, b_s1, c_s1;
  logic [W-1:0]   a_s2, b_s2, c_s2;
  logic [M-1:0]   a_s3, b_s3, c_s3;
  logic [61:0]    ab_ll, ab_lh, ab_hl, ab_hh;
  logic [M-1:0]   c_s4, c_s5, c_s6, c_s7, c_s8, c_s9;
  logic [123:0]   prod_s5;
  logic [W-1:0]   lo_s6, lo_s7, lo_s8, lo_s9;
  logic [W-1:0]   shifted_s6;
  logic [W-1:0]   f_ll, f_lh, f_hl, f_hh;
  logic [W-1:0]   qh_s8;
  logic [W-1:0]   qm_ll;
  logic [31:0]    qm_hl, qm_lh;
  logic [W-1:0]   r_s10, r_s11, r_s12;

  // Combinational helpers between stages
  logic [1:0]     oor;
  logic           err_now;
  logic [62:0]    ab_mid;
  logic [123:0]   prod_sum;
  logic [123:0]   prod_shr;
  logic [64:0]    f_mid;
  logic [127:0]   f_sum;
  logic [W-1:0]   qm_low;
  logic [W-1:0]   r_final;

  // x >= 2^k * q exactly when (x >> k) >= q
  assign oor[0] = ((a_s0 >> bound_log) >= {1'b0, modulus}) ||
                  ((b_s0 >> bound_log) >= {1'b0, modulus});
  assign oor[1] = ((c_s0 >> bound_log) >= {1'b0, modulus});
  assign err_now = |oor;

  assign ab_mid   = {1'b0, ab_lh} + {1'b0, ab_hl};
  assign prod_sum = {62'd0, ab_ll} + {30'd0, ab_mid, 31'd0} + {ab_hh, 62'd0};
  assign prod_shr = prod_s5 >> shift_amt;

  assign f_mid = {1'b0, f_lh} + {1'b0, f_hl};
  assign f_sum = {64'd0, f_ll} + {31'd0, f_mid, 32'd0} + {f_hh, 64'd0};

  assign qm_low = qm_ll + {qm_hl + qm_lh, 32'd0};

  assign r_final = mma_pkg::cond_sub(r_s12, q1);

  always_ff @(posedge clk) begin
    // capture the item
    if (en[0]) begin
      a_s0      <= operand_a;
      b_s0      <= operand_b;
      c_s0      <= addend;
      last_p[0] <= last_in;
    end
    // range check, subtract 4q
    if (en[1]) begin
      a_s1      <= mma_pkg::cond_sub({1'b0, a_s0}, q4);
      b_s1      <= mma_pkg::cond_sub({1'b0, b_s0}, q4);
      c_s1      <= mma_pkg::cond_sub({1'b0, c_s0}, q4);
      err_p[1]  <= err_now;
      zero_p[1] <= err_now || (modulus < M'(2));
      last_p[1] <= last_p[0];
    end
    // subtract 2q
    if (en[2]) begin
      a_s2 <= mma_pkg::cond_sub(a_s1, q2);
      b_s2 <= mma_pkg::cond_sub(b_s1, q2);
      c_s2 <= mma_pkg::cond_sub(c_s1, q2);
    end
    // subtract q, operands now in [0,q)
    if (en[3]) begin
      a_s3 <= M'(mma_pkg::cond_sub(a_s2, q1));
      b_s3 <= M'(mma_pkg::cond_sub(b_s2, q1));
      c_s3 <= M'(mma_pkg::cond_sub(c_s2, q1));
    end
    // a*b partial products, 31-bit halves
    if (en[4]) begin
      ab_ll <= 62'(a_s3[30:0])  * 62'(b_s3[30:0]);
      ab_lh <= 62'(a_s3[30:0])  * 62'(b_s3[61:31]);
      ab_hl <= 62'(a_s3[61:31]) * 62'(b_s3[30:0]);
      ab_hh <= 62'(a_s3[61:31]) * 62'(b_s3[61:31]);
      c_s4  <= c_s3;
    end
    // full product
    if (en[5]) begin
      prod_s5 <= prod_sum;
      c_s5    <= c_s4;
    end
    // Barrett pre-shift
    if (en[6]) begin
      shifted_s6 <= prod_shr[W-1:0];
      lo_s6      <= prod_s5[W-1:0];
      c_s6       <= c_s5;
    end
    // shifted product times barrett_factor, 32-bit halves
    if (en[7]) begin
      f_ll  <= W'(shifted_s6[31:0])  * W'(barrett_factor[31:0]);
      f_lh  <= W'(shifted_s6[31:0])  * W'(barrett_factor[63:32]);
      f_hl  <= W'(shifted_s6[63:32]) * W'(barrett_factor[31:0]);
      f_hh  <= W'(shifted_s6[63:32]) * W'(barrett_factor[63:32]);
      lo_s7 <= lo_s6;
      c_s7  <= c_s6;
    end
    // quotient estimate: high word
    if (en[8]) begin
      qh_s8 <= f_sum[127:64];
      lo_s8 <= lo_s7;
      c_s8  <= c_s7;
    end
    // low word of estimate times q
    if (en[9]) begin
      qm_ll <= W'(qh_s8[31:0]) * W'(modulus[31:0]);
      qm_hl <= 32'(qh_s8[63:32] * modulus[31:0]);
      qm_lh <= 32'(qh_s8[31:0] * {2'b00, modulus[61:32]});
      lo_s9 <= lo_s8;
      c_s9  <= c_s8;
    end
    // remainder plus addend, wrapping
    if (en[10]) begin
      r_s10 <= lo_s9 - qm_low + {2'b00, c_s9};
    end
    // final reduction
    if (en[11]) begin
      r_s11 <= mma_pkg::cond_sub(r_s10, q4);
    end
    if (en[12]) begin
      r_s12 <= mma_pkg::cond_sub(r_s11, q2);
    end
    if (en[13]) begin
      residue     <= zero_p[12] ? '0 : r_final[M-1:0];
      range_error <= err_p[12];
      last_out    <= last_p[12];
    end
    // carry flags down the pipe
    for (int i = 2; i < N - 1; i++) begin
      if (en[i]) begin
        err_p[i]  <= err_p[i-1];
        zero_p[i] <= zero_p[i-1];
        last_p[i] <= last_p[i-1];
      end
    end
  end

endmodule

`default_nettype wire

// File: dv/tb_modular_multiply_add_core.sv
// Self-checking testbench for modular_multiply_add_core: streams items through the core,
// predicts every result with a local Barrett model and checks results in order.
// Depends on mma_pkg and the core RTL.
module tb_modular_multiply_add_core;

  localparam int ModBits     = mma_pkg::ModBits;
  localparam int OperandBits = mma_pkg::OperandBits;
  localparam int WordBits    = mma_pkg::WordBits;
  localparam int Stages      = mma_pkg::Stages;

  // Index 3 maps to no register; a write there must change nothing
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int BarrettAlpha = 62;
  localparam logic [OperandBits-1:0] OPERAND_MAX = '1;
  localparam logic [ModBits-1:0] MODULUS_MAX = '1;

  typedef struct packed {
    logic [ModBits-1:0] residue;
    logic               range_error;
    logic               last;
  } mma_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   cfg_write = 1'b0;
  logic [1:0]             cfg_index = mma_pkg::REG_MODULUS;
  logic [WordBits-1:0]    cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [OperandBits-1:0] operand_a = '0;
  logic [OperandBits-1:0] operand_b = '0;
  logic [OperandBits-1:0] addend = '0;
  logic                   last_in = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [ModBits-1:0]     residue;
  logic                   range_error;
  logic                   last_out;

  // Register copies as the core should hold them after each write
  logic [ModBits-1:0]  model_modulus = ModBits'(2);
  logic [WordBits-1:0] model_barrett = '0;
  logic [3:0]          model_bound = 4'd1;

  // Expected results, oldest first
  mma_result_t pending_results[$];
  int fail_count = 0;
  bit idle_on = 1'b0;
  int stall_hold = 0;

  always #2 clk = ~clk;

  modular_multiply_add_core dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .operand_a(operand_a),
    .operand_b(operand_b),
    .addend(addend),
    .last_in(last_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .residue(residue),
    .range_error(range_error),
    .last_out(last_out)
  );

  // log2 of the operand bound: take the highest set bit of the factor, 0 acts as 1
  function automatic logic [1:0] bound_log(input logic [3:0] f);
    if (f[3]) return 2'd3;
    else if (f[2]) return 2'd2;
    else if (f[1]) return 2'd1;
    return 2'd0;
  endfunction

  function automatic int bit_len(input logic [ModBits-1:0] q);
    int n;
    int i;
    n = 0;
    for (i = 0; i < ModBits; i++) if (q[i]) n = i + 1;
    return n;
  endfunction

  // Correct Barrett factor floor(2^(L+62)/q)
  function automatic logic [WordBits-1:0] barrett_for(input logic [ModBits-1:0] q);
    logic [127:0] num;
    num = 128'd1 << (bit_len(q) + BarrettAlpha);
    return (q == '0) ? '0 : WordBits'(num / q);
  endfunction

  // Subtract 4q, 2q and q where they fit
  function automatic logic [WordBits-1:0] fold8(input logic [WordBits-1:0] x,
                                                input logic [WordBits-1:0] q);
    logic [WordBits-1:0] v;
    v = x;
    if (v >= (q << 2)) v = v - (q << 2);
    if (v >= (q << 1)) v = v - (q << 1);
    if (v >= q) v = v - q;
    return v;
  endfunction

  // (a*b + c) mod q as the core computes it, wrong factors and all
  function automatic mma_result_t mul_add_mod(input logic [OperandBits-1:0] a,
                                              input logic [OperandBits-1:0] b,
                                              input logic [OperandBits-1:0] c,
                                              input logic last);
    logic [1:0] k;
    logic [WordBits-1:0] q, ra, rb, rc, window, quot, rem, sum;
    logic [127:0] prod, est;
    int sh;
    mma_result_t r;
    k = bound_log(model_bound);
    q = WordBits'(model_modulus);
    r.last = last;
    r.residue = '0;
    // x >= 2^k * q exactly when (x >> k) >= q
    r.range_error = ((a >> k) >= model_modulus) || ((b >> k) >= model_modulus) ||
                    ((c >> k) >= model_modulus);
    if (!r.range_error && model_modulus >= 2) begin
      sh = bit_len(model_modulus) - 2;
      ra = fold8(WordBits'(a), q);
      rb = fold8(WordBits'(b), q);
      rc = fold8(WordBits'(c), q);
      prod = 128'(ra) * 128'(rb);
      window = WordBits'(prod >> sh);
      est = 128'(window) * 128'(model_barrett);
      quot = est[127:64];
      rem = prod[63:0] - quot * q;
      sum = fold8(rem + rc, q);
      r.residue = sum[ModBits-1:0];
    end
    return r;
  endfunction

  // Random operand for the current setting: mostly in range, with boundaries and noise
  function automatic logic [OperandBits-1:0] operand_pick();
    logic [65:0] lim;
    logic [127:0] wide;
    int pick;
    lim = 66'(model_modulus) << bound_log(model_bound);
    if (lim > 66'(OPERAND_MAX) + 66'd1) lim = 66'(OPERAND_MAX) + 66'd1;
    wide = {$urandom, $urandom, $urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 6) return '0;
    else if (pick < 12) return OperandBits'(lim - 66'd1);
    else if (pick < 16) return (lim > 66'(OPERAND_MAX)) ? OPERAND_MAX : OperandBits'(lim);
    else if (pick < 22) return OperandBits'(wide);
    else if (pick < 30) return OperandBits'(66'(model_modulus) + $urandom_range(0, 2) - 1);
    return OperandBits'(wide % lim);
  endfunction

  // Drop valid and wait for the pipeline to empty, then let it run dry
  task automatic settle();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 4000) begin
      @(posedge clk);
      waited++;
    end
    repeat (Stages + 2) @(posedge clk);
  endtask

  // Write all three registers back to back while the core is idle
  task automatic configure(input logic [WordBits-1:0] q_word,
                           input logic [WordBits-1:0] bf_word,
                           input logic [WordBits-1:0] f_word,
                           input bit poke_unused);
    settle();
    cfg_write <= 1'b1;
    cfg_index <= mma_pkg::REG_MODULUS;
    cfg_data <= q_word;
    @(posedge clk);
    cfg_index <= mma_pkg::REG_BARRETT_FACTOR;
    cfg_data <= bf_word;
    @(posedge clk);
    cfg_index <= mma_pkg::REG_INPUT_FACTOR;
    cfg_data <= f_word;
    @(posedge clk);
    if (poke_unused) begin
      cfg_index <= REG_UNUSED;
      cfg_data <= {$urandom, $urandom};
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    model_modulus = q_word[ModBits-1:0];
    model_barrett = bf_word;
    model_bound = f_word[3:0];
  endtask

  // Offer one item, hold it until accepted, then queue its expected result
  task automatic send_item(input logic [OperandBits-1:0] a,
                           input logic [OperandBits-1:0] b,
                           input logic [OperandBits-1:0] c,
                           input logic last);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    operand_a <= a;
    operand_b <= b;
    addend <= c;
    last_in <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(mul_add_mod(a, b, c, last));
  endtask

  // Register values straight out of reset: q of 2, factor 0, bound 1
  task automatic test_reset_defaults();
    settle();
    send_item(1, 1, 1, 1'b0);
    send_item(0, 0, 0, 1'b1);
    send_item(2, 1, 0, 1'b0);
  endtask

  // Largest modulus: all-ones operands, q-1, q and multiples of q at bounds 8 and 1
  task automatic test_operand_extremes();
    logic [OperandBits-1:0] qx;
    qx = OperandBits'(MODULUS_MAX);
    configure(WordBits'(MODULUS_MAX), barrett_for(MODULUS_MAX), 8, 1'b0);
    send_item(OPERAND_MAX, OPERAND_MAX, OPERAND_MAX, 1'b1);
    send_item(qx - 1, qx - 1, qx - 1, 1'b0);
    send_item(qx, qx << 1, qx + 1, 1'b0);
    configure(WordBits'(MODULUS_MAX), barrett_for(MODULUS_MAX), 1, 1'b0);
    send_item(qx - 1, qx - 1, 0, 1'b1);
    send_item(qx, 0, 0, 1'b0);
    send_item(0, qx, 0, 1'b0);
    send_item(0, 0, qx, 1'b1);
  endtask

  // Modulus zero flags everything, modulus one gives zero, then the two smallest moduli
  task automatic test_special_moduli();
    configure(0, 0, 8, 1'b0);
    send_item(0, 0, 0, 1'b1);
    configure(1, barrett_for(1), 2, 1'b0);
    send_item(1, 1, 1, 1'b0);
    send_item(2, 0, 0, 1'b1);
    configure(2, barrett_for(2), 4, 1'b0);
    send_item(7, 7, 7, 1'b1);
    configure(3, barrett_for(3), 2, 1'b0);
    send_item(5, 5, 5, 1'b0);
  endtask

  // Odd bound codes: 0 acts as 1, 3 as 2, 15 as 8; probe just under and at each bound
  task automatic test_factor_codes();
    configure(1000, barrett_for(1000), 0, 1'b0);
    send_item(999, 999, 999, 1'b0);
    send_item(1000, 1, 1, 1'b1);
    configure(1000, barrett_for(1000), 3, 1'b0);
    send_item(1999, 1999, 1999, 1'b0);
    send_item(1, 2000, 1, 1'b0);
    configure(1000, barrett_for(1000), 15, 1'b0);
    send_item(7999, 7999, 7999, 1'b1);
    send_item(1, 1, 8000, 1'b0);
  endtask

  // Broken Barrett factors: the datapath wraps and residue may land above q
  task automatic test_wrong_barrett();
    logic [ModBits-1:0] q;
    q = 62'h2000_0000_0000_3039;
    configure(WordBits'(MODULUS_MAX), '1, 8, 1'b0);
    send_item(OPERAND_MAX, OPERAND_MAX, OPERAND_MAX, 1'b1);
    configure(WordBits'(q), 0, 1, 1'b0);
    send_item(OperandBits'(q - 1), OperandBits'(q - 1), OperandBits'(q - 1), 1'b0);
  endtask

  // Junk above the modulus and input-factor widths, plus a write to the unused index
  task automatic test_config_masking();
    configure({2'b11, 62'd1000003}, barrett_for(1000003), {{60{1'b1}}, 4'd4}, 1'b1);
    send_item(4000011, 4000011, 123, 1'b1);
    send_item(4000012, 0, 0, 1'b0);
  endtask

  // Streams of random items over a range of settings; the last two phases run flat out
  task automatic test_random_streams();
    int phase;
    int n;
    int len;
    logic [WordBits-1:0] qw, bf, fw;
    logic [ModBits-1:0] q;
    for (phase = 0; phase < 13; phase++) begin
      len = $urandom_range(2, ModBits);
      qw = {$urandom, $urandom} >> (WordBits - len);
      qw[len - 1] = 1'b1;
      q = qw[ModBits-1:0];
      case (phase)
        0: q = MODULUS_MAX;
        1: q = ModBits'(1) << 61;
        2: q = 3;
        3: q = 2;
        default: ;
      endcase
      bf = barrett_for(q);
      if (phase == 5) bf = {$urandom, $urandom};
      if (phase == 8) bf = bf - 1;
      fw = {$urandom, $urandom};
      fw[3:0] = (phase == 6) ? 4'($urandom_range(0, 15)) : 4'(1 << $urandom_range(0, 3));
      configure({2'($urandom_range(0, 3)), q}, bf, fw, 1'b0);
      idle_on = (phase < 11);
      for (n = 0; n < 100; n++) begin
        // Mix stretches with and without idling
        if (phase < 11 && n % 25 == 0) idle_on = ($urandom_range(0, 3) != 0);
        send_item(operand_pick(), operand_pick(), operand_pick(), $urandom_range(0, 7) == 0);
      end
    end
  endtask

  // Output side: stall in random bursts while idling is on
  always @(posedge clk) begin
    if (stall_hold != 0) begin
      stall_hold--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_hold = $urandom_range(0, 11);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_results
    mma_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result item: residue %0d range_error %0b last_out %0b",
               residue, range_error, last_out);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (residue !== want.residue) begin
          $error("residue: expected %0d, got %0d", want.residue, residue);
          fail_count++;
        end
        if (range_error !== want.range_error) begin
          $error("range_error: expected %0b, got %0b", want.range_error, range_error);
          fail_count++;
        end
        if (last_out !== want.last) begin
          $error("last_out: expected %0b, got %0b", want.last, last_out);
          fail_count++;
        end
      end
    end
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #2000000;
    $display("modular_multiply_add_core: mismatch");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_operand_extremes();
    test_special_moduli();
    test_factor_codes();
    test_wrong_barrett();
    test_config_masking();
    test_random_streams();
    settle();
    if (pending_results.size() != 0) begin
      $error("%0d expected result items never arrived", pending_results.size());
      fail_count++;
    end
    if (fail_count == 0) $display("modular_multiply_add_core: match");
    else $display("modular_multiply_add_core: mismatch");
    $finish;
  end

endmodule
